>>> rtl/bbsf_pkg.sv
package bbsf_pkg;

  localparam int DEPTH_DEF   = 1024;
  localparam int MAX_REQ_DEF = 64;

  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int CNT_W  = 11;
  localparam int TOT_W  = 48;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP   = 3'd3;
  localparam logic [OP_W-1:0] OP_END   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] write_byte;
    logic [LEN_W-1:0]  request_len;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              refused;
    logic [CNT_W-1:0]  buffered;
    logic [CNT_W-1:0]  space_left;
    logic [TOT_W-1:0]  total_written;
    logic [TOT_W-1:0]  total_read;
    logic              input_closed;
    logic              at_eof;
  } out_t;

endpackage

>>> rtl/bbsf_ram.sv
module bbsf_ram #(
  parameter int DEPTH = bbsf_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [bbsf_pkg::BYTE_W-1:0]      wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [bbsf_pkg::BYTE_W-1:0]      rd_data
);
  import bbsf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/bounded_byte_stream_fifo_core.sv
// a single-result word is registered and shows on out in the cycle after it is accepted
// read/peek runs: state reg, ram read, out_word, then one byte per cycle while out_ready
// throughput: one single-result word per cycle unless out stalls; input is blocked during a run
// the byte ram read port (one read per cycle, registered data) sets the run rate
// reset: synchronous, empties the fifo, clears totals and closed, capacity back to 1024
module bounded_byte_stream_fifo_core #(
  parameter int DEPTH       = bbsf_pkg::DEPTH_DEF,
  parameter int MAX_REQUEST = bbsf_pkg::MAX_REQ_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [bbsf_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bbsf_pkg::in_t               in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bbsf_pkg::out_t              out_word
);
  import bbsf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam logic [SW-1:0]    DEPTH_S = SW'(DEPTH);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_REQUEST);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state, state_next;
  logic [CNT_W-1:0]  capacity;
  logic [AW-1:0]     head, head_next;
  logic [CNT_W-1:0]  held, held_next;
  logic [TOT_W-1:0]  wr_total, wr_total_next;
  logic [TOT_W-1:0]  rd_total, rd_total_next;
  logic              closed, closed_next;
  logic [AW-1:0]     rd_addr, rd_addr_next;
  logic [LEN_W-1:0]  issue_left, issue_left_next;
  logic [LEN_W-1:0]  deliver_left, deliver_left_next;
  logic              pending, pending_next;
  logic              out_valid_next;
  out_t              out_word_next;
  out_t              run_status, run_status_next;

  logic              accept, load, issue;
  logic              do_write, do_remove, go_run, refuse;
  logic [CNT_W-1:0]  cap_eff, space;
  logic [LEN_W-1:0]  len_c, n;
  logic              short;
  logic [SW-1:0]     tail_sum, head_sum;
  logic [AW-1:0]     tail;
  logic [BYTE_W-1:0] rd_data;
  out_t              status;

  bbsf_ram #(.DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (accept && do_write),
    .wr_addr (tail),
    .wr_data (in_word.write_byte),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign load     = (state == ST_RUN) && pending && (!out_valid || out_ready);
  assign issue    = (state == ST_RUN) && (issue_left != '0) && (!pending || load);

  always_comb begin
    cap_eff  = (SW'(capacity) > DEPTH_S) ? CNT_W'(DEPTH_S) : capacity;
    len_c    = (in_word.request_len > MAX_LEN) ? MAX_LEN : in_word.request_len;
    short    = SW'(held) < SW'(len_c);
    n        = short ? LEN_W'(held) : len_c;
    tail_sum = SW'(head) + SW'(held);
    tail     = AW'((tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum);
    head_sum = SW'(head) + SW'(n);

    do_write    = 1'b0;
    do_remove   = 1'b0;
    go_run      = 1'b0;
    refuse      = 1'b0;
    closed_next = closed;
    case (in_word.op)
      OP_WRITE: begin
        if (held < cap_eff) begin
          do_write = 1'b1;
        end else begin
          refuse = 1'b1;
        end
      end
      OP_READ: begin
        if (short) begin
          refuse = 1'b1;
        end else if (n != '0) begin
          do_remove = 1'b1;
          go_run    = 1'b1;
        end
      end
      OP_PEEK: begin
        go_run = (n != '0);
      end
      OP_POP: begin
        do_remove = 1'b1;
      end
      OP_END: begin
        closed_next = 1'b1;
      end
      default: begin
      end
    endcase
    if (!accept) begin
      closed_next = closed;
    end

    head_next     = head;
    held_next     = held;
    wr_total_next = wr_total;
    rd_total_next = rd_total;
    if (accept && do_write) begin
      held_next     = held + CNT_W'(1);
      wr_total_next = wr_total + TOT_W'(1);
    end
    if (accept && do_remove) begin
      head_next     = AW'((head_sum >= DEPTH_S) ? head_sum - DEPTH_S : head_sum);
      held_next     = held - CNT_W'(n);
      rd_total_next = rd_total + TOT_W'(n);
    end

    space = (cap_eff > held_next) ? cap_eff - held_next : '0;
    status.out_byte      = '0;
    status.last          = 1'b1;
    status.refused       = refuse;
    status.buffered      = held_next;
    status.space_left    = space;
    status.total_written = wr_total_next;
    status.total_read    = rd_total_next;
    status.input_closed  = closed_next;
    status.at_eof        = closed_next && (held_next == '0);

    state_next        = state;
    rd_addr_next      = rd_addr;
    issue_left_next   = issue_left;
    deliver_left_next = deliver_left;
    pending_next      = pending;
    run_status_next   = run_status;
    out_word_next     = out_word;

    if (accept && go_run) begin
      state_next        = ST_RUN;
      rd_addr_next      = head;
      issue_left_next   = n;
      deliver_left_next = n;
      run_status_next   = status;
    end
    if (issue) begin
      rd_addr_next    = (SW'(rd_addr) + SW'(1) == DEPTH_S) ? '0 : rd_addr + AW'(1);
      issue_left_next = issue_left - LEN_W'(1);
      pending_next    = 1'b1;
    end else if (load) begin
      pending_next = 1'b0;
    end

    if (accept && !go_run) begin
      out_word_next = status;
    end else if (load) begin
      out_word_next          = run_status;
      out_word_next.out_byte = rd_data;
      out_word_next.last     = (deliver_left == LEN_W'(1));
      deliver_left_next      = deliver_left - LEN_W'(1);
      if (deliver_left == LEN_W'(1)) begin
        state_next = ST_IDLE;
      end
    end

    if ((accept && !go_run) || load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      capacity     <= CAP_RESET;
      head         <= '0;
      held         <= '0;
      wr_total     <= '0;
      rd_total     <= '0;
      closed       <= 1'b0;
      issue_left   <= '0;
      deliver_left <= '0;
      pending      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      head         <= head_next;
      held         <= held_next;
      wr_total     <= wr_total_next;
      rd_total     <= rd_total_next;
      closed       <= closed_next;
      issue_left   <= issue_left_next;
      deliver_left <= deliver_left_next;
      pending      <= pending_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr    <= rd_addr_next;
    run_status <= run_status_next;
    out_word   <= out_word_next;
  end

endmodule

>>> rtl/bbsf_checker.sv
module bbsf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input bbsf_pkg::out_t              out_word
);
  import bbsf_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // no new word taken in the middle of a run
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.last |-> !in_ready)
    else $error("input taken during a run");

  a_refused_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.refused |-> out_word.last && (out_word.out_byte == '0))
    else $error("refused word not a lone zero result");

  a_eof: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.at_eof ==
                  (out_word.input_closed && (out_word.buffered == '0)))
    else $error("eof flag inconsistent");

  // run words carry the same buffered count and total_read throughout
  a_run_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_word.last ##1 out_valid |->
      out_word.buffered == $past(out_word.buffered) &&
      out_word.total_read == $past(out_word.total_read))
    else $error("status changed inside a run");

endmodule

bind bounded_byte_stream_fifo_core bbsf_checker u_bbsf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_word    (out_word)
);
